>>> design/sbox_differential_analyzer_macros.svh
// ----------------------------------------------------------------------------
// S-box differential analyser: assertion macros
// Shared property templates for the checker module.
// ----------------------------------------------------------------------------
`ifndef SBOX_DIFFERENTIAL_ANALYZER_MACROS_SVH
`define SBOX_DIFFERENTIAL_ANALYZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sda_pkg.sv
// ----------------------------------------------------------------------------
// S-box differential analyser package
// Shared constants, codes and control types.
// ----------------------------------------------------------------------------
package sda_pkg;

   localparam int IN_BITS_DEF  = 4;
   localparam int OUT_BITS_DEF = 4;

   localparam int ZERO_ENTRIES_W = 9;
   localparam int MAX_ENTRY_W    = 5;
   localparam int MAX_COUNT_W    = 9;
   localparam int SCORE_W        = 13;
   // The score weights the maximum entry by 256.
   localparam int SCORE_SHIFT    = 8;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_START = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAIR,
      ST_DRAIN,
      ST_FOLD
   } state_type;

   typedef struct packed {
      logic clear;
      logic step;
   } fold_ctl_type;

endpackage

>>> design/sda_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module sda_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

>>> design/sda_hist.sv
// ----------------------------------------------------------------------------
// Row histogram
// Counts output differences of one row; each entry clears as it is read out.
// ----------------------------------------------------------------------------
module sda_hist #(
   parameter int IN_BITS  = sda_pkg::IN_BITS_DEF,
   parameter int OUT_BITS = sda_pkg::OUT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                inc_en,
   input  logic [OUT_BITS-1:0] inc_addr,
   input  logic                clr_en,
   input  logic [OUT_BITS-1:0] rd_addr,
   output logic [IN_BITS:0]    rd_data
);

   localparam int OUT_SIZE = 1 << OUT_BITS;

   logic [IN_BITS:0] hist_ff [OUT_SIZE];
   logic [IN_BITS:0] hist_in [OUT_SIZE];

   always_comb begin
      for (int i = 0; i < OUT_SIZE; i++) begin
         hist_in[i] = hist_ff[i];
         if (clr_en && rd_addr == OUT_BITS'(i)) begin
            hist_in[i] = '0;
         end else if (inc_en && inc_addr == OUT_BITS'(i)) begin
            hist_in[i] = hist_ff[i] + (IN_BITS + 1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OUT_SIZE; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         hist_ff <= hist_in;
      end
   end

   assign rd_data = hist_ff[rd_addr];

endmodule

>>> design/sda_fold.sv
// ----------------------------------------------------------------------------
// Fold unit
// Shared compare and count unit that folds one histogram entry per cycle,
// while step is set, into the running table statistics.
// ----------------------------------------------------------------------------
module sda_fold #(
   parameter int IN_BITS  = sda_pkg::IN_BITS_DEF,
   parameter int OUT_BITS = sda_pkg::OUT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sda_pkg::fold_ctl_type       ctl,
   input  logic [IN_BITS:0]            entry,
   output logic [IN_BITS+OUT_BITS:0]   zero_total,
   output logic [IN_BITS:0]            best_value,
   output logic [IN_BITS+OUT_BITS:0]   best_count
);

   localparam int TW = IN_BITS + OUT_BITS + 1;
   localparam logic [IN_BITS:0] TRIVIAL = {1'b1, {IN_BITS{1'b0}}};

   logic [TW-1:0]    zero_ff, zero_in;
   logic [IN_BITS:0] best_ff, best_in;
   logic [TW-1:0]    count_ff, count_in;

   // An entry equal to the maximum is counted before the compare, so a
   // new maximum then overrides that count.
   always_comb begin
      zero_in  = zero_ff;
      best_in  = best_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         zero_in  = '0;
         best_in  = '0;
         count_in = '0;
      end else if (ctl.step) begin
         if (entry == '0) begin
            zero_in = zero_ff + TW'(1);
         end
         if (entry == best_ff) begin
            count_in = count_ff + TW'(1);
         end
         if (entry != TRIVIAL && entry > best_ff) begin
            best_in  = entry;
            count_in = TW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff  <= '0;
         best_ff  <= '0;
         count_ff <= '0;
      end else begin
         zero_ff  <= zero_in;
         best_ff  <= best_in;
         count_ff <= count_in;
      end
   end

   assign zero_total = zero_ff;
   assign best_value = best_ff;
   assign best_count = count_ff;

endmodule

>>> design/sda_ctrl.sv
// ----------------------------------------------------------------------------
// Sequencer
// Walks rows and input pairs, drives the S-box reads, the histogram and the
// fold unit, and owns both handshakes.
// ----------------------------------------------------------------------------
module sda_ctrl #(
   parameter int IN_BITS  = sda_pkg::IN_BITS_DEF,
   parameter int OUT_BITS = sda_pkg::OUT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  ram_wr_en,
   output logic                  ram_rd_en,
   output logic [IN_BITS-1:0]    ram_addr_a,
   output logic [IN_BITS-1:0]    ram_addr_b,
   output logic                  hist_inc_en,
   output logic                  hist_clr,
   output logic [OUT_BITS-1:0]   hist_rd_addr,
   output sda_pkg::fold_ctl_type fold_ctl
);

   sda_pkg::state_type state_ff, state_in;

   logic [IN_BITS-1:0]  row_ff, row_in;
   logic [IN_BITS-1:0]  pair_ff, pair_in;
   logic [OUT_BITS-1:0] col_ff, col_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic start_acc;
   logic load_acc;
   logic row_end;
   logic last_row;

   assign req_ready = (state_ff == sda_pkg::ST_IDLE) && !rsp_valid_ff;
   assign start_acc = req_valid && req_ready && (req_opcode == sda_pkg::OP_START);
   assign load_acc  = req_valid && req_ready && (req_opcode == sda_pkg::OP_LOAD);
   assign row_end   = (state_ff == sda_pkg::ST_FOLD) && (col_ff == '1);
   assign last_row  = (row_ff == '1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sda_pkg::ST_IDLE: begin
            if (start_acc) begin
               state_in = sda_pkg::ST_PAIR;
            end
         end
         sda_pkg::ST_PAIR: begin
            if (pair_ff == '1) begin
               state_in = sda_pkg::ST_DRAIN;
            end
         end
         sda_pkg::ST_DRAIN: begin
            state_in = sda_pkg::ST_FOLD;
         end
         sda_pkg::ST_FOLD: begin
            if (row_end) begin
               state_in = last_row ? sda_pkg::ST_IDLE : sda_pkg::ST_PAIR;
            end
         end
         default: begin
            state_in = sda_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      ram_wr_en      = load_acc;
      ram_rd_en      = (state_ff == sda_pkg::ST_PAIR);
      ram_addr_a     = pair_ff;
      ram_addr_b     = pair_ff ^ row_ff;
      hist_inc_en    = pend_ff;
      hist_clr       = (state_ff == sda_pkg::ST_FOLD);
      hist_rd_addr   = col_ff;
      fold_ctl.clear = start_acc;
      fold_ctl.step  = (state_ff == sda_pkg::ST_FOLD);
      rsp_valid      = rsp_valid_ff;
   end

   // Counters. The read issued in one cycle lands in the histogram in the next.
   always_comb begin
      pair_in = (state_ff == sda_pkg::ST_PAIR) ? pair_ff + IN_BITS'(1) : '0;
      col_in  = (state_ff == sda_pkg::ST_FOLD) ? col_ff + OUT_BITS'(1) : '0;
      pend_in = (state_ff == sda_pkg::ST_PAIR);
      row_in  = row_ff;
      if (start_acc) begin
         row_in = '0;
      end else if (row_end) begin
         row_in = row_ff + IN_BITS'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (row_end && last_row) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sda_pkg::ST_IDLE;
         row_ff       <= '0;
         pair_ff      <= '0;
         col_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         pair_ff      <= pair_in;
         col_ff       <= col_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/sbox_differential_analyzer.sv
// ----------------------------------------------------------------------------
// S-box differential analyser
// Builds the difference distribution table of a loaded S-box row by row and
// reports its zero count, largest non-trivial entry, that entry's count and
// a score.
//
//   Channel   Direction  Handshake            Carries
//   req_      in         req_valid/req_ready  opcode, entry index and value
//   rsp_      out        rsp_valid/rsp_ready  zero count, max, max count, score
//
// A load transaction writes one S-box entry and produces no response.
// A start transaction walks every row: one S-box read pair per cycle over all
// input pairs, a drain step, then one fold step per cycle over all histogram
// entries; the response appears after the last row's last fold step.
// No new transaction is taken while an analysis runs or a response waits.
// Reset clears the control state, the histogram and the statistics.
// ----------------------------------------------------------------------------
module sbox_differential_analyzer #(
   parameter int IN_BITS  = sda_pkg::IN_BITS_DEF,
   parameter int OUT_BITS = sda_pkg::OUT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [IN_BITS-1:0]                  req_entry_index,
   input  logic [OUT_BITS-1:0]                 req_entry_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sda_pkg::ZERO_ENTRIES_W-1:0]  rsp_zero_entries,
   output logic [sda_pkg::MAX_ENTRY_W-1:0]     rsp_max_entry,
   output logic [sda_pkg::MAX_COUNT_W-1:0]     rsp_max_count,
   output logic signed [sda_pkg::SCORE_W-1:0]  rsp_score
);

   localparam int ZERO_W  = sda_pkg::ZERO_ENTRIES_W;
   localparam int MAX_W   = sda_pkg::MAX_ENTRY_W;
   localparam int COUNT_W = sda_pkg::MAX_COUNT_W;
   localparam int SCORE_W = sda_pkg::SCORE_W;

   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [IN_BITS-1:0]    ram_addr_a;
   logic [IN_BITS-1:0]    ram_addr_b;
   logic [OUT_BITS-1:0]   sbox_a;
   logic [OUT_BITS-1:0]   sbox_b;
   logic                  hist_inc_en;
   logic                  hist_clr;
   logic [OUT_BITS-1:0]   hist_rd_addr;
   logic [IN_BITS:0]      hist_entry;
   sda_pkg::fold_ctl_type fold_ctl;

   logic [IN_BITS+OUT_BITS:0] zero_total;
   logic [IN_BITS:0]          best_value;
   logic [IN_BITS+OUT_BITS:0] best_count;

   sda_ctrl #(
      .IN_BITS (IN_BITS),
      .OUT_BITS(OUT_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .ram_wr_en   (ram_wr_en),
      .ram_rd_en   (ram_rd_en),
      .ram_addr_a  (ram_addr_a),
      .ram_addr_b  (ram_addr_b),
      .hist_inc_en (hist_inc_en),
      .hist_clr    (hist_clr),
      .hist_rd_addr(hist_rd_addr),
      .fold_ctl    (fold_ctl)
   );

   sda_ram #(
      .WIDTH(OUT_BITS),
      .DEPTH(1 << IN_BITS)
   ) u_sbox_ram (
      .clock    (clock),
      .wr_en    (ram_wr_en),
      .wr_addr  (req_entry_index),
      .wr_data  (req_entry_value),
      .rd_en    (ram_rd_en),
      .rd_addr_a(ram_addr_a),
      .rd_addr_b(ram_addr_b),
      .rd_data_a(sbox_a),
      .rd_data_b(sbox_b)
   );

   sda_hist #(
      .IN_BITS (IN_BITS),
      .OUT_BITS(OUT_BITS)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .inc_en  (hist_inc_en),
      .inc_addr(sbox_a ^ sbox_b),
      .clr_en  (hist_clr),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_entry)
   );

   sda_fold #(
      .IN_BITS (IN_BITS),
      .OUT_BITS(OUT_BITS)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fold_ctl),
      .entry     (hist_entry),
      .zero_total(zero_total),
      .best_value(best_value),
      .best_count(best_count)
   );

   assign rsp_zero_entries = ZERO_W'(zero_total);
   assign rsp_max_entry    = MAX_W'(best_value);
   assign rsp_max_count    = COUNT_W'(best_count);
   assign rsp_score        = SCORE_W'(zero_total)
                           - (SCORE_W'(best_value) << sda_pkg::SCORE_SHIFT);

endmodule

>>> design/sda_checker.sv
// ----------------------------------------------------------------------------
// S-box differential analyser checker
// Port-level properties of the analyser, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "sbox_differential_analyzer_macros.svh"

module sda_checker #(
   parameter int IN_BITS  = sda_pkg::IN_BITS_DEF,
   parameter int OUT_BITS = sda_pkg::OUT_BITS_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_opcode,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [sda_pkg::ZERO_ENTRIES_W-1:0]  rsp_zero_entries,
   input logic [sda_pkg::MAX_ENTRY_W-1:0]     rsp_max_entry,
   input logic [sda_pkg::MAX_COUNT_W-1:0]     rsp_max_count,
   input logic signed [sda_pkg::SCORE_W-1:0]  rsp_score
);

   localparam int FIELDS_W = sda_pkg::ZERO_ENTRIES_W + sda_pkg::MAX_ENTRY_W
                           + sda_pkg::MAX_COUNT_W + sda_pkg::SCORE_W;

   logic                start_acc;
   logic                load_acc;
   logic [FIELDS_W-1:0] rsp_fields;

   assign start_acc  = req_valid && req_ready && (req_opcode == sda_pkg::OP_START);
   assign load_acc   = req_valid && req_ready && (req_opcode == sda_pkg::OP_LOAD);
   assign rsp_fields = {rsp_zero_entries, rsp_max_entry, rsp_max_count, rsp_score};

   // A pending response is held until the consumer takes it.
   `SDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
      "response dropped while stalled")

   // The payload of a stalled response does not change.
   `SDA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
      $stable(rsp_fields), "response payload changed while stalled")

   // The block never takes a request while a response is outstanding.
   `SDA_ASSERT_SAME(a_no_overlap, clock, reset, rsp_valid, !req_ready,
      "request taken while a response waits")

   // A start transaction makes the block busy in the next cycle.
   `SDA_ASSERT_NEXT(a_start_busy, clock, reset, start_acc, !req_ready && !rsp_valid,
      "analysis did not begin after start")

   // A load transaction completes at once and leaves the block ready.
   `SDA_ASSERT_NEXT(a_load_ready, clock, reset, load_acc, req_ready && !rsp_valid,
      "load transaction did not complete at once")

endmodule

bind sbox_differential_analyzer sda_checker #(
   .IN_BITS (IN_BITS),
   .OUT_BITS(OUT_BITS)
) u_sda_checker (.*);
